[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FDQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// same-cycle implication
`define FDQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   `FDQ_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

// next-cycle implication
`define FDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `FDQ_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[hw/rtl/fdq_pkg.sv]
// shared constants and types of the fault debounce qualifier
`default_nettype none

package fdq_pkg;

   localparam int NUM_FAULTS_DEF = 64;

   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 16;
   localparam int ACT_W  = 32;
   localparam int EVT_W  = 8;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_EVAL = 2'd1,
      OP_EOC  = 2'd2
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_NONE      = 2'd0,
      ST_DETECTED  = 2'd1,
      ST_CONFIRMED = 2'd2
   } fault_state_type;

   // one table entry: debounce state plus the loaded profile
   typedef struct packed {
      logic [ST_W-1:0]   state;
      logic [CNT_W-1:0]  count;
      logic [WORD_W-1:0] mask;
      logic [CNT_W-1:0]  rise;
      logic [CNT_W-1:0]  fall;
      logic [CNT_W-1:0]  limit;
      logic              latch;
      logic [ACT_W-1:0]  det_act;
      logic [ACT_W-1:0]  conf_act;
      logic [ACT_W-1:0]  heal_act;
      logic [EVT_W-1:0]  events;
   } entry_type;

endpackage

`default_nettype wire

[hw/rtl/fdq_req_if.sv]
// request channel of the fault debounce qualifier
`default_nettype none

interface fdq_req_if;
   logic                        valid;
   logic                        ready;
   logic [fdq_pkg::OP_W-1:0]    opcode;
   logic [fdq_pkg::IDX_W-1:0]   err_index;
   logic [fdq_pkg::WORD_W-1:0]  module_word;
   logic [fdq_pkg::WORD_W-1:0]  fault_mask;
   logic [fdq_pkg::CNT_W-1:0]   inc_step;
   logic [fdq_pkg::CNT_W-1:0]   dec_step;
   logic [fdq_pkg::CNT_W-1:0]   max_count;
   logic                        latch_until_restart;
   logic [fdq_pkg::ACT_W-1:0]   detect_actions;
   logic [fdq_pkg::ACT_W-1:0]   confirm_actions;
   logic [fdq_pkg::ACT_W-1:0]   heal_actions;
   logic [fdq_pkg::EVT_W-1:0]   event_bits;

   modport source (
      output valid, opcode, err_index, module_word, fault_mask, inc_step, dec_step,
             max_count, latch_until_restart, detect_actions, confirm_actions,
             heal_actions, event_bits,
      input  ready
   );

   modport sink (
      input  valid, opcode, err_index, module_word, fault_mask, inc_step, dec_step,
             max_count, latch_until_restart, detect_actions, confirm_actions,
             heal_actions, event_bits,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/fdq_rsp_if.sv]
// response channel of the fault debounce qualifier
`default_nettype none

interface fdq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fdq_pkg::ST_W-1:0]   fault_state;
   logic [fdq_pkg::CNT_W-1:0]  fault_count;
   logic [fdq_pkg::ACT_W-1:0]  action_flags;
   logic [fdq_pkg::EVT_W-1:0]  event_flags;

   modport source (
      output valid, fault_state, fault_count, action_flags, event_flags,
      input  ready
   );

   modport sink (
      input  valid, fault_state, fault_count, action_flags, event_flags,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/fault_debounce_qualifier.sv]
// fault debounce qualifier: entry table, debounce step and cycle accumulators
// a request word is registered in the item stage, then its response in the result register
// throughput: one word per cycle when rsp is not stalled; table read in item stage, written back at its end
// same-entry back-to-back words are forwarded from the write port
// reset (synchronous) clears control state, then a pass over all NUM_FAULTS entries zeroes the table
// req ready stays low during that pass
`default_nettype none
`include "assert_macros.svh"

module fault_debounce_qualifier #(
   parameter int NUM_FAULTS = fdq_pkg::NUM_FAULTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fdq_req_if.sink   req_ch,
   fdq_rsp_if.source rsp_ch
);

   localparam int AW = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FAULTS - 1);

   // table memory
   fdq_pkg::entry_type mem [NUM_FAULTS];

   // table clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_idx_ff;

   // item stage
   logic                          item_vld_ff;
   logic [fdq_pkg::OP_W-1:0]      op_ff;
   logic                          idx_ok_ff;
   logic [AW-1:0]                 addr_ff;
   logic [fdq_pkg::WORD_W-1:0]    word_ff;
   fdq_pkg::entry_type            ld_ff;
   fdq_pkg::entry_type            ld_in;
   fdq_pkg::entry_type            rd_data_ff;
   logic                          fwd_hit_ff;
   fdq_pkg::entry_type            fwd_data_ff;

   // accumulators and result register
   logic [fdq_pkg::ACT_W-1:0]     action_accum_ff;
   logic [fdq_pkg::EVT_W-1:0]     event_accum_ff;
   logic                          rsp_vld_ff;
   logic [fdq_pkg::ST_W-1:0]      rsp_state_ff;
   logic [fdq_pkg::CNT_W-1:0]     rsp_count_ff;
   logic [fdq_pkg::ACT_W-1:0]     rsp_action_ff;
   logic [fdq_pkg::EVT_W-1:0]     rsp_event_ff;

   logic                          accept;
   logic                          adv;
   logic [AW-1:0]                 rd_addr;
   logic                          idx_ok;

   fdq_pkg::entry_type            cur;
   fdq_pkg::entry_type            nxt;
   logic                          seen;
   logic [fdq_pkg::CNT_W:0]       sum;
   logic                          sum_ge;
   logic                          dec_hit;
   logic [fdq_pkg::ACT_W-1:0]     act_or;
   logic [fdq_pkg::EVT_W-1:0]     evt_or;
   logic                          eval_en;
   logic                          load_en;
   logic [fdq_pkg::ACT_W-1:0]     action_new;
   logic [fdq_pkg::EVT_W-1:0]     event_new;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   fdq_pkg::entry_type            wr_data;
   fdq_pkg::entry_type            item_wr;

   // handshake
   assign adv           = item_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready  = !clr_busy_ff && (!item_vld_ff || adv);
   assign accept        = req_ch.valid && req_ch.ready;
   assign rd_addr       = AW'(req_ch.err_index);
   assign idx_ok        = 32'(req_ch.err_index) < NUM_FAULTS;

   always_comb begin
      ld_in          = '0;
      ld_in.mask     = req_ch.fault_mask;
      ld_in.rise     = req_ch.inc_step;
      ld_in.fall     = req_ch.dec_step;
      ld_in.limit    = req_ch.max_count;
      ld_in.latch    = req_ch.latch_until_restart;
      ld_in.det_act  = req_ch.detect_actions;
      ld_in.conf_act = req_ch.confirm_actions;
      ld_in.heal_act = req_ch.heal_actions;
      ld_in.events   = req_ch.event_bits;
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   // item stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (accept) begin
         item_vld_ff <= 1'b1;
      end else if (adv) begin
         item_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_ch.opcode;
         idx_ok_ff   <= idx_ok;
         addr_ff     <= rd_addr;
         word_ff     <= req_ch.module_word;
         ld_ff       <= ld_in;
         // a write landing in the read cycle is newer than the read data
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   // table memory, read-first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   // debounce step
   always_comb begin
      nxt     = cur;
      act_or  = '0;
      evt_or  = '0;
      seen    = |(word_ff & cur.mask);
      sum     = {1'b0, cur.count} + {1'b0, cur.rise};
      sum_ge  = sum >= {1'b0, cur.limit};
      dec_hit = cur.count <= cur.fall;
      case (cur.state)
         fdq_pkg::ST_NONE: begin
            if (seen) begin
               act_or = cur.det_act;
               if (cur.rise < cur.limit) begin
                  nxt.state = fdq_pkg::ST_DETECTED;
                  nxt.count = cur.rise;
               end else begin
                  // step is already at or above the limit: confirm at once
                  nxt.state = fdq_pkg::ST_CONFIRMED;
                  nxt.count = cur.limit;
                  act_or    = cur.det_act | cur.conf_act;
                  evt_or    = cur.events;
               end
            end
         end
         fdq_pkg::ST_DETECTED: begin
            if (seen) begin
               if (sum_ge) begin
                  nxt.state = fdq_pkg::ST_CONFIRMED;
                  nxt.count = cur.limit;
                  act_or    = cur.conf_act;
                  evt_or    = cur.events;
               end else begin
                  nxt.count = sum[fdq_pkg::CNT_W-1:0];
               end
            end else if (dec_hit) begin
               nxt.state = fdq_pkg::ST_NONE;
               nxt.count = '0;
            end else begin
               nxt.count = cur.count - cur.fall;
            end
         end
         fdq_pkg::ST_CONFIRMED: begin
            if (cur.latch) begin
               act_or = cur.conf_act;
               evt_or = cur.events;
            end else if (seen) begin
               nxt.count = sum_ge ? cur.limit : sum[fdq_pkg::CNT_W-1:0];
               act_or    = cur.conf_act;
               evt_or    = cur.events;
            end else if (dec_hit) begin
               nxt.state = fdq_pkg::ST_NONE;
               nxt.count = '0;
               act_or    = cur.heal_act;
            end else begin
               nxt.count = cur.count - cur.fall;
               act_or    = cur.conf_act;
               evt_or    = cur.events;
            end
         end
         default: begin
         end
      endcase
   end

   assign eval_en    = idx_ok_ff && (op_ff == fdq_pkg::OP_EVAL);
   assign load_en    = idx_ok_ff && (op_ff == fdq_pkg::OP_LOAD);
   assign action_new = action_accum_ff | (eval_en ? act_or : '0);
   assign event_new  = event_accum_ff | (eval_en ? evt_or : '0);

   // write-back: a load keeps the debounce state, an evaluate keeps the profile
   always_comb begin
      item_wr = nxt;
      if (load_en) begin
         item_wr       = ld_ff;
         item_wr.state = cur.state;
         item_wr.count = cur.count;
      end
   end

   assign wr_en   = clr_busy_ff || (adv && (load_en || eval_en));
   assign wr_addr = clr_busy_ff ? clr_idx_ff : addr_ff;
   assign wr_data = clr_busy_ff ? '0 : item_wr;

   // accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         action_accum_ff <= '0;
         event_accum_ff  <= '0;
      end else if (adv) begin
         if (op_ff == fdq_pkg::OP_EOC) begin
            action_accum_ff <= '0;
            event_accum_ff  <= '0;
         end else begin
            action_accum_ff <= action_new;
            event_accum_ff  <= event_new;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!idx_ok_ff || op_ff == fdq_pkg::OP_EOC) begin
            rsp_state_ff <= fdq_pkg::ST_NONE;
            rsp_count_ff <= '0;
         end else if (eval_en) begin
            rsp_state_ff <= nxt.state;
            rsp_count_ff <= nxt.count;
         end else begin
            rsp_state_ff <= cur.state;
            rsp_count_ff <= cur.count;
         end
         rsp_action_ff <= action_new;
         rsp_event_ff  <= event_new;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.fault_state  = rsp_state_ff;
   assign rsp_ch.fault_count  = rsp_count_ff;
   assign rsp_ch.action_flags = rsp_action_ff;
   assign rsp_ch.event_flags  = rsp_event_ff;

   `FDQ_ASSERT_NOW(a_idle_while_clearing, clock, reset, clr_busy_ff, !item_vld_ff && !rsp_vld_ff, "pipeline busy during table clear")
   `FDQ_ASSERT_NEXT(a_eoc_clears, clock, reset, adv && op_ff == fdq_pkg::OP_EOC, action_accum_ff == '0 && event_accum_ff == '0, "end of cycle left accumulators set")
   `FDQ_ASSERT_NEXT(a_eoc_zero_entry, clock, reset, adv && (op_ff == fdq_pkg::OP_EOC || !idx_ok_ff), rsp_ch.fault_state == fdq_pkg::ST_NONE && rsp_ch.fault_count == '0, "entry fields not zero on report or bad index")
   `FDQ_ASSERT_NEXT(a_accum_keeps_bits, clock, reset, adv && op_ff != fdq_pkg::OP_EOC, (action_accum_ff & $past(action_accum_ff)) == $past(action_accum_ff) && (event_accum_ff & $past(event_accum_ff)) == $past(event_accum_ff), "accumulator lost bits")

endmodule

`default_nettype wire
